// ===== rtl/core/lfia_pkg.sv =====
// Shared constants, codes, command and status types and encoders of the identifier allocator.
package lfia_pkg;

   // Identifier space and bitmap organisation
   localparam int ID_COUNT    = 4096;
   localparam int ID_W        = 12;
   localparam int LF_W        = 13;
   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = ID_COUNT / WORD_BITS;
   localparam int WORD_W      = $clog2(WORD_COUNT);
   localparam int GROUP_SIZE  = 16;
   localparam int GRP_BIT_W   = $clog2(GROUP_SIZE);
   localparam int GROUP_COUNT = WORD_COUNT / GROUP_SIZE;
   localparam int GROUP_W     = WORD_W - GRP_BIT_W;

   localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // Request actions
   localparam logic [1:0] ACT_ALLOC    = 2'd0;
   localparam logic [1:0] ACT_FREE     = 2'd1;
   localparam logic [1:0] ACT_REGISTER = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BAD_ID = 2'd2;

   // Strobes from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic modify;
      logic scan_word;
      logic scan_sum;
      logic scan_hit;
      logic rsp_load;
   } cmd_type;

   // Decisions reported by the datapath
   typedef struct packed {
      logic dec_rmw;
      logic mod_scan;
      logic word_hit;
      logic word_last;
      logic grp_hit;
      logic grp_last;
      logic rsp_busy;
   } stat_type;

   // Index of the lowest set bit of a bitmap word
   function automatic logic [BIT_W-1:0] lowest_bit_word(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // Index of the lowest set flag within a group of words
   function automatic logic [GRP_BIT_W-1:0] lowest_bit_group(input logic [GROUP_SIZE-1:0] v);
      logic [GRP_BIT_W-1:0] idx;
      idx = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = GRP_BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/lfia_ctrl.sv =====
// Sequencing state machine of the identifier allocator.
module lfia_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lfia_pkg::stat_type stat,
   output lfia_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DECODE    = 7'b0000010,
      S_MODIFY    = 7'b0000100,
      S_SCAN_WORD = 7'b0001000,
      S_SCAN_SUM  = 7'b0010000,
      S_SCAN_HIT  = 7'b0100000,
      S_RESP      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Take a request only between operations
   assign req_ready = (state_ff == S_IDLE);

   // Drive the datapath strobes from the current state
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.decode    = (state_ff == S_DECODE);
      cmd.modify    = (state_ff == S_MODIFY);
      cmd.scan_word = (state_ff == S_SCAN_WORD);
      cmd.scan_sum  = (state_ff == S_SCAN_SUM);
      cmd.scan_hit  = (state_ff == S_SCAN_HIT);
      cmd.rsp_load  = (state_ff == S_RESP) && !stat.rsp_busy;
   end

   // Advance through decode, read-modify-write and scan
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = stat.dec_rmw ? S_MODIFY : S_RESP;
         end
         S_MODIFY: begin
            state_in = stat.mod_scan ? S_SCAN_WORD : S_RESP;
         end
         S_SCAN_WORD: begin
            state_in = (stat.word_hit || stat.word_last) ? S_RESP : S_SCAN_SUM;
         end
         S_SCAN_SUM: begin
            if (stat.grp_hit) state_in = S_SCAN_HIT;
            else if (stat.grp_last) state_in = S_RESP;
         end
         S_SCAN_HIT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lfia_datapath.sv =====
// Bitmap store, full-word summary, lowest-free pointer and response register.
module lfia_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lfia_pkg::cmd_type            cmd,
   output lfia_pkg::stat_type           stat,
   input  logic [1:0]                   req_action,
   input  logic [lfia_pkg::ID_W-1:0]    req_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lfia_pkg::ID_W-1:0]    rsp_given_id,
   output logic [1:0]                   rsp_status
);

   localparam int WB = lfia_pkg::WORD_BITS;
   localparam int WW = lfia_pkg::WORD_W;
   localparam int BW = lfia_pkg::BIT_W;
   localparam int GW = lfia_pkg::GROUP_W;
   localparam int GB = lfia_pkg::GRP_BIT_W;
   localparam int GS = lfia_pkg::GROUP_SIZE;
   localparam int IW = lfia_pkg::ID_W;
   localparam int LW = lfia_pkg::LF_W;

   // Bitmap words, row valid flags and full-word summary
   logic [WB-1:0]                      mem [lfia_pkg::WORD_COUNT];
   logic [lfia_pkg::WORD_COUNT-1:0]    valid_ff, valid_in;
   logic [lfia_pkg::WORD_COUNT-1:0]    full_ff, full_in;
   logic [WB-1:0]                      rd_word_ff;
   logic                               rd_valid_ff;

   logic [1:0]    act_ff, act_in;
   logic [IW-1:0] id_ff, id_in;
   logic [LW-1:0] lf_ff, lf_in;
   logic [IW-1:0] target_ff, target_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic [WW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] given_ff, given_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_given_ff, rsp_given_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          is_alloc, is_free, is_reg, id_ok, lf_full;
   logic [WB-1:0] cur_word, bit_mask, new_word, word_free;
   logic [LW-1:0] scan_start;
   logic          need_scan;
   logic [WW-1:0] scan_word_idx;
   logic [GW-1:0] grp;
   logic [GS-1:0] grp_open;
   logic [WW-1:0] hit_word;
   logic          rd_en, wr_en;
   logic [WW-1:0] rd_addr, wr_addr;

   // Decode the held request
   assign is_alloc = (act_ff == lfia_pkg::ACT_ALLOC);
   assign is_free  = (act_ff == lfia_pkg::ACT_FREE);
   assign is_reg   = (act_ff == lfia_pkg::ACT_REGISTER);
   assign id_ok    = (id_ff != '0) && ({1'b0, id_ff} < LW'(lfia_pkg::ID_COUNT));
   assign lf_full  = (lf_ff >= LW'(lfia_pkg::ID_COUNT)) || (lf_ff == '0);

   // Word as read, with never-written rows reading as all free
   assign cur_word   = rd_valid_ff ? rd_word_ff : '0;
   assign bit_mask   = WB'(1) << target_ff[BW-1:0];
   assign new_word   = is_free ? (cur_word & ~bit_mask) : (cur_word | bit_mask);
   assign scan_start = {1'b0, target_ff} + LW'(1);
   assign need_scan  = is_alloc || (is_reg && ({1'b0, target_ff} == lf_ff));

   // Free bits of the scan word at or above the start position, or of a hit word
   assign scan_word_idx = scan_ff[BW +: WW];
   assign word_free     = cmd.scan_hit ? ~cur_word
                                       : (~cur_word & (lfia_pkg::ALL_ONES << scan_ff[BW-1:0]));

   // Open words of the current summary group at or above the pointer
   assign grp      = ptr_ff[WW-1:GB];
   assign grp_open = ~full_ff[grp*GS +: GS] & ({GS{1'b1}} << ptr_ff[GB-1:0]);
   assign hit_word = {grp, lfia_pkg::lowest_bit_group(grp_open)};

   // Report decisions to the controller
   always_comb begin
      stat           = '0;
      stat.dec_rmw   = (is_alloc && !lf_full) || ((is_free || is_reg) && id_ok);
      stat.mod_scan  = need_scan && !scan_start[LW-1];
      stat.word_hit  = |word_free;
      stat.word_last = (scan_word_idx == WW'(lfia_pkg::WORD_COUNT - 1));
      stat.grp_hit   = |grp_open;
      stat.grp_last  = (grp == GW'(lfia_pkg::GROUP_COUNT - 1));
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   // Select the memory port addresses
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = target_ff[BW +: WW];
      if (cmd.decode) begin
         rd_en   = stat.dec_rmw;
         rd_addr = is_alloc ? lf_ff[BW +: WW] : id_ff[BW +: WW];
      end else if (cmd.modify) begin
         rd_en   = stat.mod_scan;
         rd_addr = scan_start[BW +: WW];
      end else if (cmd.scan_sum) begin
         rd_en   = stat.grp_hit;
         rd_addr = hit_word;
      end
      wr_en   = cmd.modify;
      wr_addr = target_ff[BW +: WW];
   end

   // Next values of the request, pointer and response registers
   always_comb begin
      act_in        = act_ff;
      id_in         = id_ff;
      lf_in         = lf_ff;
      target_in     = target_ff;
      scan_in       = scan_ff;
      ptr_in        = ptr_ff;
      given_in      = given_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      full_in       = full_ff;
      rsp_given_in  = rsp_given_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      // Hold the accepted request
      if (cmd.capture) begin
         act_in = req_action;
         id_in  = req_id;
      end

      // Classify and pick the target identifier
      if (cmd.decode) begin
         target_in = is_alloc ? lf_ff[IW-1:0] : id_ff;
         given_in  = (is_alloc && !lf_full) ? lf_ff[IW-1:0] : '0;
         if (is_alloc) begin
            status_in = lf_full ? lfia_pkg::ST_FULL : lfia_pkg::ST_DONE;
         end else if (is_free || is_reg) begin
            status_in = id_ok ? lfia_pkg::ST_DONE : lfia_pkg::ST_BAD_ID;
         end else begin
            status_in = lfia_pkg::ST_DONE;
         end
      end

      // Write back the updated word and move the pointer
      if (cmd.modify) begin
         valid_in[wr_addr] = 1'b1;
         full_in[wr_addr]  = (new_word == lfia_pkg::ALL_ONES);
         if (is_free) begin
            if ({1'b0, target_ff} < lf_ff) lf_in = {1'b0, target_ff};
         end else if (need_scan) begin
            scan_in = scan_start;
            if (scan_start[LW-1]) lf_in = LW'(lfia_pkg::ID_COUNT);
         end
      end

      // Look for a free bit in the start word
      if (cmd.scan_word) begin
         if (stat.word_hit) begin
            lf_in = LW'({scan_word_idx, lfia_pkg::lowest_bit_word(word_free)});
         end else if (stat.word_last) begin
            lf_in = LW'(lfia_pkg::ID_COUNT);
         end else begin
            ptr_in = scan_word_idx + WW'(1);
         end
      end

      // Step the summary one group at a time
      if (cmd.scan_sum) begin
         if (stat.grp_hit) begin
            ptr_in = hit_word;
         end else if (stat.grp_last) begin
            lf_in = LW'(lfia_pkg::ID_COUNT);
         end else begin
            ptr_in = {grp + GW'(1), GB'(0)};
         end
      end

      // Take the lowest free bit of the open word
      if (cmd.scan_hit) begin
         lf_in = LW'({ptr_ff, lfia_pkg::lowest_bit_word(word_free)});
      end

      // Load the response register
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_given_in  = given_ff;
         rsp_status_in = status_ff;
      end
   end

   // Bitmap memory with write-through on a same-row read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= new_word;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_word_ff  <= new_word;
            rd_valid_ff <= 1'b1;
         end else begin
            rd_word_ff  <= mem[rd_addr];
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         full_ff      <= '0;
         lf_ff        <= LW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         full_ff      <= full_in;
         lf_ff        <= lf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      id_ff         <= id_in;
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      ptr_ff        <= ptr_in;
      given_ff      <= given_in;
      status_ff     <= status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_given_id = rsp_given_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== rtl/core/lowest_free_id_allocator.sv =====
// Top level of the lowest-free identifier allocator.
//
// Request channel (req_valid/req_ready): req_action selects allocate, free or
// register; req_id names the identifier for free and register. Every request
// produces exactly one response on rsp_valid/rsp_ready carrying rsp_given_id
// (the handed-out identifier for a successful allocate, else zero) and
// rsp_status (done, nothing free, or bad identifier).
// Requests are handled one at a time. Rejected requests and unknown actions
// go from decode straight to the response; free, and register of another
// identifier, read-modify-write one 32-bit bitmap word and then respond.
// Allocate, and register of the pointed identifier, read-modify-write the word
// and, unless the target is the last identifier, scan for the next free one:
// first the start word, then, if it has no free bit and is not the last word,
// the full-word summary one group of 16 words at a time and, on a hit, a read of
// the open word. One bitmap read per cycle and the summary walk bound the scan.
// The next request is accepted in the cycle after the response is loaded.
// Reset empties the map (row valid flags clear at once, no clearing pass) and
// sets the pointer to 1; identifier 0 is never handed out.
// A stalled receiver holds the response register; processing waits only where
// a further response would need the still occupied register.
module lowest_free_id_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [lfia_pkg::ID_W-1:0] req_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lfia_pkg::ID_W-1:0] rsp_given_id,
   output logic [1:0]                rsp_status
);

   lfia_pkg::cmd_type  cmd;
   lfia_pkg::stat_type stat;

   // Sequencer
   lfia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Bitmap, pointer and response datapath
   lfia_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_action   (req_action),
      .req_id       (req_id),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_given_id (rsp_given_id),
      .rsp_status   (rsp_status)
   );

endmodule
